// ----- design/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants for the haze transmission estimator.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int MAX_WIDTH       = 2048;
  localparam int MAX_HEIGHT      = 2048;
  localparam int MAX_RADIUS      = 7;
  localparam int RATIO_FRAC_BITS = 12;

  localparam int SLOTS      = 2 * MAX_RADIUS + 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = SLOTS * MAX_WIDTH;
  localparam int SHIFT_W    = 8 + RATIO_FRAC_BITS;
  localparam int QUO_W      = 8 + SHIFT_W;
  localparam int DEN_W      = 16;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS       = 3'd2;
  localparam logic [2:0] REG_KEEP         = 3'd3;
  localparam logic [2:0] REG_AIR_BLUE     = 3'd4;
  localparam logic [2:0] REG_AIR_GREEN    = 3'd5;
  localparam logic [2:0] REG_AIR_RED      = 3'd6;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // one stage of the restoring divider chain
  typedef struct packed {
    logic             valid;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

endpackage

// ----- design/haze_transmission_estimate.sv -----
// ----------------------------------------------------------------------------
// haze_transmission_estimate
// Dark channel prior transmission estimate over a clipped square window.
// ----------------------------------------------------------------------------
// Pixels are stored into a 15-row line store as they arrive. After each
// word the block checks whether the oldest pending window is complete,
// through the CHECK and TEST states. A word that yields a result scans its
// window through the single read port of the line store, one pixel a cycle,
// then feeds the three channel minimums through a 28-cell divider chain
// and then scales and rounds the result. Results wait in an output
// register, so a new word is taken while a result waits; the next result
// waits for that register to empty.
module haze_transmission_estimate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        s_tuser,   // operation: 0 pixel, 1 drain
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // transmission[12:0], clamped[13], center_row[24:14],
                                 // center_col[35:25], zero fill[39:36]
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hte_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_CHECK = 8'b00000010,
    ST_TEST  = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_FLUSH = 8'b00010000,
    ST_DIV   = 8'b00100000,
    ST_MUL   = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_t;

  state_t state;

  // configuration
  logic [11:0] frame_width, frame_height;
  logic [2:0]  window_radius;
  logic [8:0]  haze_keep_factor;
  logic [15:0] air_light [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 12'd640;
      frame_height     <= 12'd480;
      window_radius    <= 3'd7;
      haze_keep_factor <= 9'd243;
      air_light[0]     <= 16'd56320;
      air_light[1]     <= 16'd56320;
      air_light[2]     <= 16'd56320;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width      <= cfg_data[11:0];
        REG_FRAME_HEIGHT: frame_height     <= cfg_data[11:0];
        REG_RADIUS:       window_radius    <= cfg_data[2:0];
        REG_KEEP:         haze_keep_factor <= cfg_data[8:0];
        REG_AIR_BLUE:     air_light[0]     <= cfg_data;
        REG_AIR_GREEN:    air_light[1]     <= cfg_data;
        REG_AIR_RED:      air_light[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [11:0] w_eff, h_eff;
  always_comb begin
    w_eff = (frame_width == 12'd0) ? 12'd1 :
            (frame_width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : frame_width;
    h_eff = (frame_height == 12'd0) ? 12'd1 :
            (frame_height > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : frame_height;
  end

  // positions
  logic [10:0]       input_row, input_col, emit_row, emit_col;
  logic [SLOT_W-1:0] input_slot, emit_slot;
  logic              frame_received;

  // line store
  logic [23:0]       mem [0:MEM_DEPTH-1];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [23:0]       mem_q;
  logic              rd_valid;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // a finished frame restarts at the top left corner
  logic [SLOT_W-1:0] wr_slot;
  logic [10:0]       wr_col, wr_row;
  logic              in_col_wrap, in_row_wrap;
  always_comb begin
    wr_slot     = (frame_received) ? '0 : input_slot;
    wr_col      = (frame_received) ? '0 : input_col;
    wr_row      = (frame_received) ? '0 : input_row;
    wr_addr     = {wr_slot, wr_col};
    mem_we      = accept && (s_tuser == OP_PIXEL);
    in_col_wrap = (12'(wr_col) + 12'd1 >= w_eff);
    in_row_wrap = (12'(wr_row) + 12'd1 >= h_eff);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= s_tdata;
    end
    mem_q <= mem[rd_addr];
  end

  // window bounds from emit position
  logic [11:0]       nr_sum, nc_sum;
  logic [10:0]       rlo, clo, rhi, chi;
  logic [3:0]        row_back;
  logic [SLOT_W-1:0] slot_lo;
  always_comb begin
    nr_sum   = {1'b0, emit_row} + 12'(window_radius);
    nc_sum   = {1'b0, emit_col} + 12'(window_radius);
    rlo      = (emit_row >= 11'(window_radius)) ? emit_row - 11'(window_radius) : 11'd0;
    clo      = (emit_col >= 11'(window_radius)) ? emit_col - 11'(window_radius) : 11'd0;
    rhi      = (nr_sum > h_eff - 12'd1) ? 11'(h_eff - 12'd1) : nr_sum[10:0];
    chi      = (nc_sum > w_eff - 12'd1) ? 11'(w_eff - 12'd1) : nc_sum[10:0];
    row_back = 4'(emit_row - rlo);
    slot_lo  = (emit_slot >= SLOT_W'(row_back)) ? emit_slot - SLOT_W'(row_back) :
               SLOT_W'(5'(emit_slot) + 5'(SLOTS) - 5'(row_back));
  end

  // completeness test operands, registered in CHECK
  logic [23:0]       prod_emit, prod_in;
  logic [10:0]       r_rlo, r_rhi, r_clo, r_chi, r_nc, r_incol;
  logic [SLOT_W-1:0] r_slot_lo;
  logic              win_ready;
  always_comb begin
    win_ready = frame_received ||
                ((prod_emit + 24'(r_nc)) < (prod_in + 24'(r_incol)));
  end

  // scan
  logic [10:0]       scan_row, scan_col;
  logic [SLOT_W-1:0] scan_slot;
  logic [7:0]        mins [0:2];
  assign rd_addr = {scan_slot, scan_col};

  // divider
  logic              div_in_valid, div_out_valid;
  logic [QUO_W-1:0]  div_num, div_quo, best;
  logic [DEN_W-1:0]  div_den;
  logic [1:0]        feed_cnt, got_cnt;
  logic [QUO_W+8:0]  scaled;

  always_comb begin
    div_in_valid = (state == ST_DIV) && (feed_cnt != 2'd3);
    div_num      = '0;
    div_den      = 16'd1;
    case (feed_cnt)
      2'd0: begin
        div_num = {mins[0], SHIFT_W'(0)};
        div_den = (air_light[0] == 16'd0) ? 16'd1 : air_light[0];
      end
      2'd1: begin
        div_num = {mins[1], SHIFT_W'(0)};
        div_den = (air_light[1] == 16'd0) ? 16'd1 : air_light[1];
      end
      2'd2: begin
        div_num = {mins[2], SHIFT_W'(0)};
        div_den = (air_light[2] == 16'd0) ? 16'd1 : air_light[2];
      end
      default: ;
    endcase
  end

  hte_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_in_valid),
    .in_num    (div_num),
    .in_den    (div_den),
    .out_valid (div_out_valid),
    .out_quo   (div_quo)
  );

  // final scaling
  localparam logic [QUO_W+8:0] ONE_FIX = (QUO_W+9)'(1) << SHIFT_W;
  logic             is_clamped;
  logic [QUO_W+8:0] t_full;
  logic [12:0]      t_val;
  logic             is_last;
  always_comb begin
    is_clamped = (scaled > ONE_FIX);
    t_full     = (ONE_FIX - scaled + ((QUO_W+9)'(1) << (RATIO_FRAC_BITS - 5)))
                 >> (RATIO_FRAC_BITS - 4);
    t_val      = is_clamped ? 13'd0 : t_full[12:0];
    is_last    = ({1'b0, emit_col} >= w_eff - 12'd1) && ({1'b0, emit_row} >= h_eff - 12'd1);
  end

  logic [12:0] out_t;
  logic        out_clamped, out_last;
  logic [10:0] out_row, out_col;
  assign m_tdata = {4'd0, out_col, out_row, out_clamped, out_t};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      input_row      <= '0;
      input_col      <= '0;
      input_slot     <= '0;
      emit_row       <= '0;
      emit_col       <= '0;
      emit_slot      <= '0;
      frame_received <= 1'b0;
      rd_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      feed_cnt       <= '0;
      got_cnt        <= '0;
    end else begin
      // in FIN the output register is either reloaded or still waiting
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == ST_SCAN);
      if (rd_valid) begin
        for (int c = 0; c < 3; c++) begin
          if (mem_q[8*c +: 8] < mins[c]) begin
            mins[c] <= mem_q[8*c +: 8];
          end
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CHECK;
            if (s_tuser == OP_PIXEL) begin
              if (frame_received) begin
                emit_row  <= '0;
                emit_col  <= '0;
                emit_slot <= '0;
              end
              frame_received <= in_col_wrap && in_row_wrap;
              if (in_col_wrap) begin
                input_col <= '0;
                if (in_row_wrap) begin
                  input_row  <= '0;
                  input_slot <= '0;
                end else begin
                  input_row  <= wr_row + 11'd1;
                  input_slot <= (wr_slot == SLOT_W'(SLOTS - 1)) ? '0 : wr_slot + 1'b1;
                end
              end else begin
                input_col  <= wr_col + 11'd1;
                input_row  <= wr_row;
                input_slot <= wr_slot;
              end
            end
          end
        end
        ST_CHECK: begin
          prod_emit <= 24'(rhi * w_eff);
          prod_in   <= 24'(input_row * w_eff);
          r_nc      <= chi;
          r_incol   <= input_col;
          r_rlo     <= rlo;
          r_rhi     <= rhi;
          r_clo     <= clo;
          r_chi     <= chi;
          r_slot_lo <= slot_lo;
          state     <= ST_TEST;
        end
        ST_TEST: begin
          if (!win_ready) begin
            state <= ST_IDLE;
          end else begin
            for (int c = 0; c < 3; c++) begin
              mins[c] <= 8'hFF;
            end
            scan_row  <= r_rlo;
            scan_col  <= r_clo;
            scan_slot <= r_slot_lo;
            feed_cnt  <= '0;
            got_cnt   <= '0;
            if (r_rlo <= r_rhi && r_clo <= r_chi) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_SCAN: begin
          if (scan_col == r_chi) begin
            scan_col <= r_clo;
            if (scan_row == r_rhi) begin
              state <= ST_FLUSH;
            end else begin
              scan_row  <= scan_row + 11'd1;
              scan_slot <= (scan_slot == SLOT_W'(SLOTS - 1)) ? '0 : scan_slot + 1'b1;
            end
          end else begin
            scan_col <= scan_col + 11'd1;
          end
        end
        ST_FLUSH: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_in_valid) begin
            feed_cnt <= feed_cnt + 2'd1;
          end
          if (div_out_valid) begin
            got_cnt <= got_cnt + 2'd1;
            if (got_cnt == 2'd0 || div_quo < best) begin
              best <= div_quo;
            end
            if (got_cnt == 2'd2) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          scaled <= (QUO_W+9)'(haze_keep_factor * best);
          state  <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_t       <= t_val;
            out_clamped <= is_clamped;
            out_row     <= emit_row;
            out_col     <= emit_col;
            out_last    <= is_last;
            state       <= ST_IDLE;
            if (is_last) begin
              emit_row       <= '0;
              emit_col       <= '0;
              emit_slot      <= '0;
              frame_received <= 1'b0;
            end else if (12'(emit_col) + 12'd1 >= w_eff) begin
              emit_col  <= '0;
              emit_row  <= emit_row + 11'd1;
              emit_slot <= (emit_slot == SLOT_W'(SLOTS - 1)) ? '0 : emit_slot + 1'b1;
            end else begin
              emit_col <= emit_col + 11'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ap_got_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> got_cnt != 2'd3)
    else $error("more quotients collected than channels");
  ap_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_out_valid |-> state == ST_DIV)
    else $error("divider result outside divide phase");
  ap_t_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_t <= 13'd4096)
    else $error("transmission above one");
  ap_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_clamped) |-> out_t == 13'd0)
    else $error("clamped result not zero");

endmodule

// ----- design/hte_div_cell.sv -----
// ----------------------------------------------------------------------------
// hte_div_cell
// One restoring division step: takes one dividend bit, passes to neighbor.
// ----------------------------------------------------------------------------
module hte_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  hte_pkg::div_stage_t stage_in,
  output hte_pkg::div_stage_t stage_out
);
  import hte_pkg::*;

  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial = {stage_in.rem, stage_in.num[QUO_W-1]};
    qbit  = (trial >= {1'b0, stage_in.den});
    if (qbit) begin
      rem_next = DEN_W'(trial - {1'b0, stage_in.den});
    end else begin
      rem_next = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.den <= stage_in.den;
    stage_out.rem <= rem_next;
    stage_out.num <= {stage_in.num[QUO_W-2:0], 1'b0};
    stage_out.quo <= {stage_in.quo[QUO_W-2:0], qbit};
  end

endmodule

// ----- design/hte_divider.sv -----
// ----------------------------------------------------------------------------
// hte_divider
// Row of division cells, one quotient bit per cell, a new word each cycle.
// ----------------------------------------------------------------------------
module hte_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [hte_pkg::QUO_W-1:0] in_num,
  input  logic [hte_pkg::DEN_W-1:0] in_den,
  output logic                    out_valid,
  output logic [hte_pkg::QUO_W-1:0] out_quo
);
  import hte_pkg::*;

  div_stage_t chain [0:QUO_W];

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].den   = in_den;
    chain[0].rem   = '0;
    chain[0].num   = in_num;
    chain[0].quo   = '0;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    hte_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  assign out_valid = chain[QUO_W].valid;
  assign out_quo   = chain[QUO_W].quo;

endmodule
